// ===== design/gbsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbsc_pkg: gas burner sequence controller package
// Transaction types, configuration register layout and register indexes.
// ----------------------------------------------------------------------------
package gbsc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERHEAT_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MARGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNITION_TRIES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REGULATION_BAND  = 3'd4;

  localparam logic [11:0] RST_OVERHEAT_LIMIT  = 12'd800;
  localparam logic [11:0] RST_RELEASE_MARGIN  = 12'd50;
  localparam logic [3:0]  RST_IGNITION_TRIES  = 4'd3;
  localparam logic [15:0] RST_SETTLE_TICKS    = 16'd40;
  localparam logic [7:0]  RST_REGULATION_BAND = 8'd2;

  typedef struct packed {
    logic signed [12:0] temperature;
    logic               flame_present;
    logic               heat_request;
    logic [7:0]         setpoint;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       gas_solenoid_on;
    logic       main_valve_open;
  } out_item_t;

  typedef struct packed {
    logic [11:0] overheat_limit;
    logic [11:0] safety_release_margin;
    logic [3:0]  ignition_try_limit;
    logic [15:0] settle_ticks;
    logic [7:0]  regulation_band;
  } cfg_t;

endpackage
`default_nettype wire

// ===== design/gbsc_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbsc_cfg: configuration registers
// Holds the five threshold and timing registers written through the port.
// ----------------------------------------------------------------------------
module gbsc_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gbsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output gbsc_pkg::cfg_t                        cfg_o
);
  import gbsc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.overheat_limit        <= RST_OVERHEAT_LIMIT;
      cfg_r.safety_release_margin <= RST_RELEASE_MARGIN;
      cfg_r.ignition_try_limit    <= RST_IGNITION_TRIES;
      cfg_r.settle_ticks          <= RST_SETTLE_TICKS;
      cfg_r.regulation_band       <= RST_REGULATION_BAND;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OVERHEAT_LIMIT:  cfg_r.overheat_limit        <= cfg_wdata[11:0];
        REG_RELEASE_MARGIN:  cfg_r.safety_release_margin <= cfg_wdata[11:0];
        REG_IGNITION_TRIES:  cfg_r.ignition_try_limit    <= cfg_wdata[3:0];
        REG_SETTLE_TICKS:    cfg_r.settle_ticks          <= cfg_wdata[15:0];
        REG_REGULATION_BAND: cfg_r.regulation_band       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule
`default_nettype wire

// ===== design/gbsc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gbsc_seq: burner sequence state machine
// Six-state burner sequence with retry and settle counters and latched
// actuator levels; advances once per fired transaction.
// ----------------------------------------------------------------------------
module gbsc_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire gbsc_pkg::in_item_t item,
  input  wire gbsc_pkg::cfg_t     cfg,
  output gbsc_pkg::out_item_t     result
);
  import gbsc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_IGNITION  = 3'd1,
    ST_SAFETY    = 3'd2,
    ST_HEATING   = 3'd3,
    ST_STABILIZE = 3'd4,
    ST_CLOSE     = 3'd5
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        sol_r, sol_nxt;
  logic        valve_r, valve_nxt;

  logic signed [13:0] temp_x;
  logic signed [13:0] limit_x;
  logic signed [13:0] release_x;
  logic signed [13:0] sp_lo;
  logic signed [13:0] sp_hi;
  logic [3:0]         att_inc;

  assign temp_x    = {item.temperature[12], item.temperature};
  assign limit_x   = $signed({2'b00, cfg.overheat_limit});
  assign release_x = limit_x - $signed({2'b00, cfg.safety_release_margin});
  assign sp_lo     = $signed({6'b0, item.setpoint}) - $signed({6'b0, cfg.regulation_band});
  assign sp_hi     = $signed({6'b0, item.setpoint}) + $signed({6'b0, cfg.regulation_band});
  assign att_inc   = (att_r != 4'hF) ? att_r + 4'd1 : att_r;

  always_comb begin
    state_nxt = state_r;
    att_nxt   = att_r;
    cnt_nxt   = cnt_r;
    sol_nxt   = sol_r;
    valve_nxt = valve_r;
    case (state_r)
      ST_IDLE: begin
        sol_nxt   = 1'b0;
        valve_nxt = 1'b0;
        if (item.heat_request && (temp_x < limit_x)) begin
          state_nxt = ST_IGNITION;
          att_nxt   = 4'd0;
        end else if (temp_x > limit_x) begin
          state_nxt = ST_SAFETY;
        end
      end
      ST_IGNITION: begin
        sol_nxt = 1'b1;
        if (item.flame_present) begin
          valve_nxt = 1'b1;
          state_nxt = ST_STABILIZE;
          cnt_nxt   = 16'd0;
        end else begin
          att_nxt = att_inc;
          if (att_inc >= cfg.ignition_try_limit) begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_HEATING: begin
        if (temp_x < sp_lo) begin
          valve_nxt = 1'b1;
        end else if (temp_x > sp_hi) begin
          valve_nxt = 1'b0;
          state_nxt = ST_STABILIZE;
        end
        if (!item.heat_request || !item.flame_present) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_STABILIZE: begin
        if (cnt_r > cfg.settle_ticks) begin
          state_nxt = ST_HEATING;
        end
        if (cnt_r != 16'hFFFF) begin
          cnt_nxt = cnt_r + 16'd1;
        end
        if (!item.heat_request) begin
          state_nxt = ST_CLOSE;
        end
      end
      ST_SAFETY: begin
        sol_nxt   = 1'b0;
        valve_nxt = 1'b0;
        if (temp_x < release_x) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        sol_nxt   = 1'b0;
        valve_nxt = 1'b0;
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      att_r   <= 4'd0;
      cnt_r   <= 16'd0;
      sol_r   <= 1'b0;
      valve_r <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
      att_r   <= att_nxt;
      cnt_r   <= cnt_nxt;
      sol_r   <= sol_nxt;
      valve_r <= valve_nxt;
    end
  end

  assign result.mode            = state_nxt;
  assign result.gas_solenoid_on = sol_nxt;
  assign result.main_valve_open = valve_nxt;

endmodule
`default_nettype wire

// ===== design/gas_burner_sequence_controller_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gas_burner_sequence_controller_unit: gas burner sequence controller
// Each input transaction is one control tick; each tick yields one result
// transaction with the new sequence state and the actuator levels.
// ----------------------------------------------------------------------------
// A tick is taken every clock cycle unless the result side stalls. A tick
// passes an input register, then the state machine update and a result
// register, from which its result is offered. The state update of the sequence
// machine sets this rate. Stall on the result side holds the result register
// and then the input register; the user must write configuration only while
// no tick is in flight, which the block itself does not enforce.
module gas_burner_sequence_controller_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire gbsc_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output gbsc_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [gbsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gbsc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gbsc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;
  logic      fire;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  gbsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  gbsc_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
